FILE: hdl/ipv4_text_range_matcher_top_macros.svh
// Assertion macros shared by the matcher RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef IPV4_TEXT_RANGE_MATCHER_TOP_MACROS_SVH
`define IPV4_TEXT_RANGE_MATCHER_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ITRM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define ITRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/itrm_pkg.sv
// Types and constants for the dotted-decimal IPv4 matcher.
// No dependencies.
`default_nettype none

package itrm_pkg;

   localparam int unsigned ADDR_W      = 32;
   localparam int unsigned OCTET_W     = 8;
   localparam int unsigned PREFIX_W    = 24;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   // octet*10 + 9 peaks at 2559
   localparam int unsigned ACC_W       = 12;

   localparam logic [7:0]  CHAR_DOT    = 8'h2E;
   localparam logic [7:0]  CHAR_ZERO   = 8'h30;
   localparam logic [7:0]  CHAR_NINE   = 8'h39;
   localparam logic [ACC_W-1:0] OCTET_MAX = ACC_W'(255);
   localparam logic [1:0]  LAST_OCTET  = 2'd3;

   // register select: byte address bit 2
   localparam logic REG_RANGE_LOW  = 1'b0;
   localparam logic REG_RANGE_HIGH = 1'b1;

   localparam logic [ADDR_W-1:0] RANGE_LOW_RESET  = '0;
   localparam logic [ADDR_W-1:0] RANGE_HIGH_RESET = '1;

   typedef struct packed {
      logic [7:0] char_code;
      logic       is_end;
   } req_item_type;

   typedef struct packed {
      logic              in_range;
      logic              well_formed;
      logic [ADDR_W-1:0] parsed_address;
   } rsp_item_type;

   // parser verdict for the string being closed
   typedef struct packed {
      logic              well_formed;
      logic [ADDR_W-1:0] address;
   } parse_status_type;

endpackage

`default_nettype wire

FILE: hdl/itrm_parser.sv
// Per-character dotted-decimal parse state and end-of-string verdict.
// Depends on itrm_pkg.
`default_nettype none

module itrm_parser (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire itrm_pkg::req_item_type     item,
   output itrm_pkg::parse_status_type      status
);
   import itrm_pkg::*;

   logic [PREFIX_W-1:0] prefix_ff, prefix_in;
   logic [1:0]          index_ff, index_in;
   logic [OCTET_W-1:0]  octet_ff, octet_in;
   logic                seen_ff, seen_in;
   logic                failed_ff, failed_in;

   logic                is_digit;
   logic                is_dot;
   logic [ACC_W-1:0]    acc;

   assign is_digit = (item.char_code >= CHAR_ZERO) && (item.char_code <= CHAR_NINE);
   assign is_dot   = (item.char_code == CHAR_DOT);
   // octet*10 + digit, as shifts
   assign acc = {1'b0, octet_ff, 3'b000} + {3'b000, octet_ff, 1'b0}
              + {4'b0000, item.char_code - CHAR_ZERO};

   always_comb begin
      prefix_in = prefix_ff;
      index_in  = index_ff;
      octet_in  = octet_ff;
      seen_in   = seen_ff;
      failed_in = failed_ff;
      if (accept) begin
         if (item.is_end) begin
            prefix_in = '0;
            index_in  = '0;
            octet_in  = '0;
            seen_in   = 1'b0;
            failed_in = 1'b0;
         end else if (!failed_ff) begin
            if (is_digit) begin
               if (acc > OCTET_MAX) begin
                  failed_in = 1'b1;
               end else begin
                  octet_in = acc[OCTET_W-1:0];
                  seen_in  = 1'b1;
               end
            end else if (is_dot) begin
               if (!seen_ff || index_ff == LAST_OCTET) begin
                  failed_in = 1'b1;
               end else begin
                  prefix_in = {prefix_ff[PREFIX_W-OCTET_W-1:0], octet_ff};
                  index_in  = index_ff + 2'd1;
                  octet_in  = '0;
                  seen_in   = 1'b0;
               end
            end else begin
               failed_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= '0;
         index_ff  <= '0;
         octet_ff  <= '0;
         seen_ff   <= 1'b0;
         failed_ff <= 1'b0;
      end else begin
         prefix_ff <= prefix_in;
         index_ff  <= index_in;
         octet_ff  <= octet_in;
         seen_ff   <= seen_in;
         failed_ff <= failed_in;
      end
   end

   // verdict as of the state before the end item
   assign status.well_formed = !failed_ff && seen_ff && (index_ff == LAST_OCTET);
   assign status.address     = status.well_formed ? {prefix_ff, octet_ff} : '0;

endmodule

`default_nettype wire

FILE: hdl/ipv4_text_range_matcher_top.sv
// Top level of the dotted-decimal IPv4 parser with address range check.
// Depends on itrm_pkg, itrm_parser and ipv4_text_range_matcher_top_macros.svh.
//
// Usage:
//   req channel: one text character per item (char_code), or an end item
//   (is_end = 1) that closes the string. Characters give no result; each
//   end item gives exactly one rsp item: well_formed, parsed_address (zero
//   when malformed) and in_range against [range_low, range_high].
//   csr port: APB-style, range_low at byte 0, range_high at byte 4. Write
//   only while idle. Reads return the register value; pready is tied high.
// Timing:
//   One item per cycle while req_stall is low. An end item's result is
//   registered in the result register (or skid). The parse update is a x10
//   accumulate plus compare; the range check is two 32-bit compares, both combinational.
// Stall:
//   The result register is backed by a one-item skid register. While rsp
//   stalls, characters keep flowing and one more end item is absorbed; req
//   stalls only when the skid register is occupied.
// Reset:
//   Synchronous, active high. Clears parse state, both result slots, and
//   loads range_low = 0, range_high = all ones (everything matches).
`default_nettype none
`include "ipv4_text_range_matcher_top_macros.svh"

module ipv4_text_range_matcher_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // item input
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire itrm_pkg::req_item_type              req_item,
   // result output
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      itrm_pkg::rsp_item_type              rsp_item,
   // configuration
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [itrm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [itrm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output      logic [itrm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output      logic                                csr_pready
);
   import itrm_pkg::*;

   logic                 req_accept;
   logic                 rsp_accept;
   logic                 new_result;
   logic                 csr_write;

   logic [ADDR_W-1:0]    range_low_ff, range_low_in;
   logic [ADDR_W-1:0]    range_high_ff, range_high_in;

   parse_status_type     status;
   rsp_item_type         result;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_item_ff, rsp_item_in;
   logic                 skid_valid_ff, skid_valid_in;
   rsp_item_type         skid_item_ff, skid_item_in;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign new_result = req_accept && req_item.is_end;

   // ---------------- configuration registers ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      range_low_in  = range_low_ff;
      range_high_in = range_high_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_RANGE_LOW:  range_low_in  = csr_pwdata;
            REG_RANGE_HIGH: range_high_in = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_RANGE_LOW:  csr_prdata = range_low_ff;
         REG_RANGE_HIGH: csr_prdata = range_high_ff;
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= RANGE_LOW_RESET;
         range_high_ff <= RANGE_HIGH_RESET;
      end else begin
         range_low_ff  <= range_low_in;
         range_high_ff <= range_high_in;
      end
   end

   // ---------------- parser ----------------
   itrm_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .item   (req_item),
      .status (status)
   );

   // range check on the closing string; malformed address is already zero
   assign result.well_formed    = status.well_formed;
   assign result.parsed_address = status.address;
   assign result.in_range       = status.well_formed
                                  && (range_low_ff <= status.address)
                                  && (status.address <= range_high_ff);

   // ---------------- result register + skid ----------------
   // skid occupied means the next end item would have nowhere to go
   assign req_stall = skid_valid_ff;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_item_in   = rsp_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (!rsp_valid_ff || rsp_accept) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = new_result;
            if (new_result) begin
               rsp_item_in = result;
            end
         end
      end else if (new_result) begin
         skid_valid_in = 1'b1;
         skid_item_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_item_ff  <= rsp_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // ---------------- checks ----------------
   `ITRM_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff,
      "skid holds an item while the result register is empty")
   `ITRM_ASSERT_NOW(a_range_needs_form, clock, reset, rsp_valid_ff && rsp_item_ff.in_range,
      rsp_item_ff.well_formed, "in_range set on a malformed string")
   `ITRM_ASSERT_NOW(a_bad_addr_zero, clock, reset, rsp_valid_ff && !rsp_item_ff.well_formed,
      rsp_item_ff.parsed_address == '0, "malformed string reports a nonzero address")
   `ITRM_ASSERT_NEXT(a_stalled_end_skids, clock, reset,
      new_result && rsp_valid_ff && rsp_stall && !skid_valid_ff, skid_valid_ff,
      "end item taken under stall was not held in skid")

endmodule

`default_nettype wire
